// ===== src/worley_cell_noise_shader_unit_macros.svh =====
// assertion macros shared by the worley cell noise shader unit
// no dependencies
`ifndef WORLEY_CELL_NOISE_SHADER_UNIT_MACROS_SVH
`define WORLEY_CELL_NOISE_SHADER_UNIT_MACROS_SVH

// same-cycle implication
`define WCNS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wcns assertion failed");

// next-cycle implication
`define WCNS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wcns assertion failed");

`endif

// ===== src/wcns_pkg.sv =====
// shared types, constants and the axis move function for the shader unit
// no dependencies
package wcns_pkg;

   localparam int GRID_COLS_DEF = 16;
   localparam int GRID_ROWS_DEF = 16;
   localparam int NUM_CELLS_DEF = 16;

   localparam int POS_W = 14;
   localparam int VEL_W = 6;
   localparam int DIF_W = 15;
   localparam int D_W   = 30;
   localparam int SQ_W  = D_W + 16;
   localparam int R_W   = SQ_W / 2;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_SHADE = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
   } cell_type;

   typedef struct packed {
      logic [POS_W-1:0]        pos;
      logic signed [VEL_W-1:0] vel;
   } axis_type;

   function automatic axis_type move_axis(input logic [POS_W-1:0] pos,
                                          input logic signed [VEL_W-1:0] vel,
                                          input logic [POS_W-1:0] limit);
      axis_type          r;
      logic signed [POS_W+1:0] p;
      p = $signed({2'b00, pos}) + (POS_W+2)'(vel);
      r.pos = p[POS_W-1:0];
      r.vel = vel;
      if (p < 0) begin
         r.pos = '0;
         r.vel = -vel;
      end else if (p > $signed({2'b00, limit})) begin
         r.pos = limit;
         r.vel = -vel;
      end
      return r;
   endfunction

endpackage

// ===== src/worley_cell_noise_shader_unit.sv =====
// worley cell noise shader top level: ring of feature cells, distance walk, roots
// depends on wcns_pkg, wcns_cell, wcns_sqrt and the macros header
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | func, cell, load fields, pixel
//   rsp     | out       | rsp_valid/rsp_stall  | hue, brightness
//
// load and tick act on the cells as they are accepted; the ring of cells moves all cells at once
// shade runs ring rotation and compare in the walk state, then waits for
// the bit-serial root units and their done flag, then writes the result into
// the output register
// synchronous reset clears the control state; cell contents are undefined
// the input stalls while a shade is in flight or its result waits for a slot
`include "worley_cell_noise_shader_unit_macros.svh"
module worley_cell_noise_shader_unit
   import wcns_pkg::*;
#(
   parameter int GRID_COLS = GRID_COLS_DEF,
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int NUM_CELLS = NUM_CELLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_func,
   input  logic [3:0]       req_cell_index,
   input  logic [11:0]      req_load_x,
   input  logic [11:0]      req_load_y,
   input  logic signed [5:0] req_load_vx,
   input  logic signed [5:0] req_load_vy,
   input  logic [3:0]       req_pixel_col,
   input  logic [3:0]       req_pixel_row,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_hue,
   output logic [7:0]       rsp_brightness
);

   localparam int IDX_W = $clog2(NUM_CELLS);
   localparam int CNT_W = $clog2(NUM_CELLS + 2);
   localparam logic [POS_W-1:0] LIMIT_X = POS_W'((GRID_COLS - 1) << 8);
   localparam logic [POS_W-1:0] LIMIT_Y = POS_W'((GRID_ROWS - 1) << 8);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [11:0]      px_ff, px_in, py_ff, py_in;
   logic             a_vld_ff, a_vld_in;
   logic [IDX_W-1:0] a_idx_ff;
   logic [D_W-1:0]   sqx_ff, sqy_ff, sqx_in, sqy_in, dsum;
   logic [D_W-1:0]   d1_ff, d1_in, d2_ff, d2_in;
   logic [IDX_W-1:0] near_ff, near_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       hue_ff, hue_in, bri_ff, bri_in;

   logic accept, shift_en, tick_en, sq_start, sq_done, sq_done2, slot_free;
   logic signed [DIF_W-1:0] dx, dy;
   logic signed [D_W-1:0]   dx_w, dy_w;
   logic [R_W-1:0]   s1, s2, sdiff;
   logic [R_W-11:0]  sshift;
   cell_type         load_data;
   cell_type         ring [NUM_CELLS];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign tick_en   = accept && (req_func == FUNC_TICK);
   assign shift_en  = (state_ff == ST_WALK) && (cnt_ff < CNT_W'(NUM_CELLS));
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      load_data.pos_x = {2'b00, req_load_x};
      load_data.pos_y = {2'b00, req_load_y};
      load_data.vel_x = req_load_vx;
      load_data.vel_y = req_load_vy;
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      wcns_cell #(
         .LIMIT_X (LIMIT_X),
         .LIMIT_Y (LIMIT_Y)
      ) u_cell (
         .clock     (clock),
         .load_en   (accept && (req_func == FUNC_LOAD) && (int'(req_cell_index) == i)),
         .load_data (load_data),
         .tick_en   (tick_en),
         .shift_en  (shift_en),
         .shift_in  (ring[(i + 1) % NUM_CELLS]),
         .cell_out  (ring[i])
      );
   end

   // distance of the head cell, squares registered before the compare
   always_comb begin
      dx     = $signed({1'b0, ring[0].pos_x}) - $signed({3'b000, px_ff});
      dy     = $signed({1'b0, ring[0].pos_y}) - $signed({3'b000, py_ff});
      dx_w   = D_W'(dx);
      dy_w   = D_W'(dy);
      sqx_in = $unsigned(dx_w * dx_w);
      sqy_in = $unsigned(dy_w * dy_w);
      dsum   = sqx_ff + sqy_ff;
   end

   assign sq_start = (state_ff == ST_WALK) && (cnt_ff == CNT_W'(NUM_CELLS + 1));

   wcns_sqrt u_sqrt1 (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (d1_ff),
      .root    (s1),
      .done    (sq_done)
   );

   wcns_sqrt u_sqrt2 (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (d2_ff),
      .root    (s2),
      .done    (sq_done2)
   );

   always_comb begin
      sdiff  = s2 - s1;
      sshift = sdiff[R_W-1:10];
      bri_in = bri_ff;
      hue_in = hue_ff;
      if (|sshift[R_W-11:8]) begin
         bri_in = 8'hff;
      end else begin
         bri_in = sshift[7:0];
      end
      hue_in = 8'({near_ff, 4'h0});
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      a_vld_in     = shift_en;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      near_in      = near_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_SHADE)) begin
               state_in = ST_WALK;
               cnt_in   = '0;
               px_in    = {req_pixel_col, 8'h00};
               py_in    = {req_pixel_row, 8'h00};
               d1_in    = '1;
               d2_in    = '1;
               near_in  = '0;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (a_vld_ff) begin
               if (dsum < d1_ff) begin
                  d2_in   = d1_ff;
                  d1_in   = dsum;
                  near_in = a_idx_ff;
               end else if (dsum < d2_ff) begin
                  d2_in = dsum;
               end
            end
            if (sq_start) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      a_idx_ff <= cnt_ff[IDX_W-1:0];
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      near_ff  <= near_in;
      if ((state_ff == ST_DONE) && slot_free) begin
         hue_ff <= hue_in;
         bri_ff <= bri_in;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_vld_ff     <= a_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_brightness = bri_ff;

   `WCNS_ASSERT_IMP(a_order, clock, reset, state_ff != ST_IDLE, d1_ff <= d2_ff)
   `WCNS_ASSERT_IMP(a_roots, clock, reset, sq_done, sq_done2 && (state_ff == ST_ROOT))
   `WCNS_ASSERT_NXT(a_rsp_src, clock, reset, !rsp_valid_ff && (state_ff != ST_DONE), !rsp_valid_ff)
   `WCNS_ASSERT_IMP(a_cnt, clock, reset, state_ff == ST_WALK, cnt_ff <= CNT_W'(NUM_CELLS + 1))

endmodule

// ===== src/wcns_cell.sv =====
// one feature cell of the ring: holds position and velocity, moves on tick
// depends on wcns_pkg
module wcns_cell
   import wcns_pkg::*;
#(
   parameter logic [POS_W-1:0] LIMIT_X = POS_W'(15 << 8),
   parameter logic [POS_W-1:0] LIMIT_Y = POS_W'(15 << 8)
) (
   input  logic     clock,
   input  logic     load_en,
   input  cell_type load_data,
   input  logic     tick_en,
   input  logic     shift_en,
   input  cell_type shift_in,
   output cell_type cell_out
);

   cell_type cell_ff, cell_in;
   axis_type ax, ay;

   always_comb begin
      ax = move_axis(cell_ff.pos_x, cell_ff.vel_x, LIMIT_X);
      ay = move_axis(cell_ff.pos_y, cell_ff.vel_y, LIMIT_Y);
      cell_in = cell_ff;
      if (load_en) begin
         cell_in = load_data;
      end else if (tick_en) begin
         cell_in.pos_x = ax.pos;
         cell_in.vel_x = ax.vel;
         cell_in.pos_y = ay.pos;
         cell_in.vel_y = ay.vel;
      end else if (shift_en) begin
         cell_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_out = cell_ff;

endmodule

// ===== src/wcns_sqrt.sv =====
// iterative integer square root of (d << 16), one result bit per cycle
// depends on wcns_pkg
module wcns_sqrt
   import wcns_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [D_W-1:0] operand,
   output logic [R_W-1:0] root,
   output logic           done
);

   logic [SQ_W-1:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = res_ff + bit_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = {operand, 16'h0000};
         res_in  = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = res_ff[R_W-1:0];
   assign done = done_ff;

endmodule
